FILE: sv/lkvc_pkg.sv
// Shared constants and types for the LRU key-value cache.
package lkvc_pkg;

    // Widths of the request and response fields at the ports
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int OUT_W   = 32;

    // Defaults for the top-level parameters
    localparam int DEF_ENTRIES    = 8;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;

    // Request modes
    localparam logic MODE_SET = 1'b0;
    localparam logic MODE_GET = 1'b1;

    // Control broadcast to every cell in the row
    typedef struct packed {
        logic en;      // request is being resolved this cycle
        logic is_set;  // set request: cells may shift
    } t_cell_ctl;

endpackage

FILE: sv/lkvc_cell.sv
// One slot of the recency-ordered row: holds a key/value pair and matches it.
module lkvc_cell #(
    parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lkvc_pkg::t_cell_ctl     i_ctl,
    input  logic [KEY_BITS-1:0]     i_search_key,
    // contents of the neighbor in front (or the new pair for the first cell)
    input  logic [KEY_BITS-1:0]     i_nb_key,
    input  logic [VALUE_BITS-1:0]   i_nb_value,
    input  logic                    i_nb_valid,
    // match seen in a cell further to the front
    input  logic                    i_hit,
    input  logic [VALUE_BITS-1:0]   i_value_acc,
    output logic [KEY_BITS-1:0]     o_key,
    output logic [VALUE_BITS-1:0]   o_value,
    output logic                    o_valid,
    output logic                    o_hit,
    output logic [VALUE_BITS-1:0]   o_value_acc
);

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_valid;
    logic                  w_match;
    logic                  w_shift;

    assign w_match = r_valid && (r_key == i_search_key);
    // On a set, cells up to and including the hit slot move back; a set miss moves them all.
    assign w_shift = i_ctl.en && i_ctl.is_set && !i_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_shift) begin
            r_valid <= i_nb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_key   <= i_nb_key;
            r_value <= i_nb_value;
        end
    end

    assign o_key       = r_key;
    assign o_value     = r_value;
    assign o_valid     = r_valid;
    assign o_hit       = i_hit | w_match;
    // At most one slot holds a given key, so OR-ing is a select.
    assign o_value_acc = i_value_acc |
                         ((w_match && !i_ctl.is_set) ? r_value : '0);

endmodule

FILE: sv/lru_key_value_cache.sv
// Top level of the LRU key-value cache: request capture, cell row, response register.
//
// Fully associative store of ENTRIES key/value slots in recency order, built as a
// row of cells. A request is first captured in the request registers; then the row
// matches the key in every cell, ripples the hit down the row and, on a set, shifts
// the cells in front of the hit (or all of them on a miss) back by one while the
// new pair enters the first cell. The response lands in an output register, so
// the next request is taken while it waits; resolution stalls only when that
// register is still full. Set returns found = key was present and value_out = 0;
// get returns found and the stored value (0 on a miss) without reordering.
module lru_key_value_cache #(
    parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_mode,
    input  logic signed [lkvc_pkg::KEY_W-1:0] i_key,
    input  logic [lkvc_pkg::VALUE_W-1:0]      i_value_in,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_found,
    output logic [lkvc_pkg::OUT_W-1:0]        o_value_out
);

    logic                              r_busy;
    logic                              r_mode;
    logic [lkvc_pkg::KEY_W-1:0]        r_key;
    logic [lkvc_pkg::VALUE_W-1:0]      r_value;
    logic                              r_out_valid;
    logic                              r_found;
    logic [lkvc_pkg::OUT_W-1:0]        r_value_out;

    logic                              w_exec;
    logic [KEY_BITS-1:0]               w_key;
    logic [VALUE_BITS-1:0]             w_value;
    logic [lkvc_pkg::OUT_W-1:0]        w_value_out;
    lkvc_pkg::t_cell_ctl               w_ctl;

    logic [KEY_BITS-1:0]               w_key_ch   [0:ENTRIES];
    logic [VALUE_BITS-1:0]             w_value_ch [0:ENTRIES];
    logic                              w_valid_ch [0:ENTRIES];
    logic                              w_hit_ch   [0:ENTRIES];
    logic [VALUE_BITS-1:0]             w_acc_ch   [0:ENTRIES];

    assign o_ready = !r_busy;
    assign w_exec  = r_busy && (!r_out_valid || i_ready);

    // Fit request fields to the stored widths (key is signed: sign-extend)
    generate
        if (KEY_BITS <= lkvc_pkg::KEY_W) begin : g_key_trunc
            assign w_key = r_key[KEY_BITS-1:0];
        end else begin : g_key_ext
            assign w_key = {{(KEY_BITS-lkvc_pkg::KEY_W){r_key[lkvc_pkg::KEY_W-1]}}, r_key};
        end
        if (VALUE_BITS <= lkvc_pkg::VALUE_W) begin : g_val_trunc
            assign w_value = r_value[VALUE_BITS-1:0];
        end else begin : g_val_ext
            assign w_value = {{(VALUE_BITS-lkvc_pkg::VALUE_W){1'b0}}, r_value};
        end
        if (VALUE_BITS >= lkvc_pkg::OUT_W) begin : g_out_trunc
            assign w_value_out = w_acc_ch[ENTRIES][lkvc_pkg::OUT_W-1:0];
        end else begin : g_out_ext
            assign w_value_out = {{(lkvc_pkg::OUT_W-VALUE_BITS){1'b0}}, w_acc_ch[ENTRIES]};
        end
    endgenerate

    assign w_ctl.en     = w_exec;
    assign w_ctl.is_set = (r_mode == lkvc_pkg::MODE_SET);

    // First cell is fed the new pair
    assign w_key_ch[0]   = w_key;
    assign w_value_ch[0] = w_value;
    assign w_valid_ch[0] = 1'b1;
    assign w_hit_ch[0]   = 1'b0;
    assign w_acc_ch[0]   = '0;

    generate
        for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
            lkvc_cell #(
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_search_key (w_key),
                .i_nb_key     (w_key_ch[g]),
                .i_nb_value   (w_value_ch[g]),
                .i_nb_valid   (w_valid_ch[g]),
                .i_hit        (w_hit_ch[g]),
                .i_value_acc  (w_acc_ch[g]),
                .o_key        (w_key_ch[g+1]),
                .o_value      (w_value_ch[g+1]),
                .o_valid      (w_valid_ch[g+1]),
                .o_hit        (w_hit_ch[g+1]),
                .o_value_acc  (w_acc_ch[g+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_busy <= 1'b1;
            end else if (w_exec) begin
                r_busy <= 1'b0;
            end
            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_mode  <= i_mode;
            r_key   <= i_key;
            r_value <= i_value_in;
        end
        if (w_exec) begin
            r_found     <= w_hit_ch[ENTRIES];
            r_value_out <= w_value_out;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_found     = r_found;
    assign o_value_out = r_value_out;

endmodule

FILE: sv/lkvc_checker.sv
// Port-level assertions for the LRU key-value cache, bound to the top level.
module lkvc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic                              o_found,
    input logic [lkvc_pkg::OUT_W-1:0]        o_value_out
);

    // A stalled response holds its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_found) && $stable(o_value_out))
        else $error("response changed while stalled");

    // One request in flight: no second accept right after one
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request accepted while previous one unresolved");

    // A miss never carries a value
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_value_out == '0)
        else $error("value reported without a hit");

    // Empty response path: request registered, then response registered
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !o_valid |=> ##1 o_valid)
        else $error("response missing two cycles after request");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_found     (o_found),
    .o_value_out (o_value_out)
);
